FILE: hw/rtl/drrm_pkg.sv
// ----------------------------------------------------------------------------
// drrm_pkg
// Shared types and codes for the damage-region list merger.
// ----------------------------------------------------------------------------
package drrm_pkg;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_CLEAR  = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_MERGED   = 3'd2;
  localparam logic [2:0] ST_FALLBACK = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  localparam logic [1:0] REG_BOUND_X = 2'd0;
  localparam logic [1:0] REG_BOUND_Y = 2'd1;
  localparam logic [1:0] REG_BOUND_W = 2'd2;
  localparam logic [1:0] REG_BOUND_H = 2'd3;

  // Pairwise geometry results from the shared compare unit.
  typedef struct packed {
    logic merge_ok;
    logic clip_empty;
    box_t clip;
    box_t hull;
  } geo_t;

endpackage

FILE: hw/rtl/drrm_geom.sv
// ----------------------------------------------------------------------------
// drrm_geom
// Shared geometry unit: clip, hull and merge test of two boxes.
// ----------------------------------------------------------------------------
module drrm_geom (
  input  drrm_pkg::box_t a,
  input  drrm_pkg::box_t b,
  output drrm_pkg::geo_t res
);
  import drrm_pkg::*;

  logic [16:0] ra, rb, ba, bb, rr, bt, rh, bh;
  logic [15:0] l, t, hx, hy;
  logic [16:0] hw, hh;
  logic a_e, b_e, touch_x, touch_y;

  always_comb begin
    ra = {1'b0, a.x} + {1'b0, a.w};
    rb = {1'b0, b.x} + {1'b0, b.w};
    ba = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    l  = (a.x > b.x) ? a.x : b.x;
    t  = (a.y > b.y) ? a.y : b.y;
    rr = (ra < rb) ? ra : rb;
    bt = (ba < bb) ? ba : bb;
    res.clip_empty = (rr <= {1'b0, l}) || (bt <= {1'b0, t});
    res.clip.x = l;
    res.clip.y = t;
    res.clip.w = 16'(rr - {1'b0, l});
    res.clip.h = 16'(bt - {1'b0, t});
    hx = (a.x < b.x) ? a.x : b.x;
    hy = (a.y < b.y) ? a.y : b.y;
    rh = (ra > rb) ? ra : rb;
    bh = (ba > bb) ? ba : bb;
    hw = rh - {1'b0, hx};
    hh = bh - {1'b0, hy};
    res.hull.x = hx;
    res.hull.y = hy;
    res.hull.w = hw[16] ? 16'hFFFF : hw[15:0];
    res.hull.h = hh[16] ? 16'hFFFF : hh[15:0];
    a_e = (a.w == '0) || (a.h == '0);
    b_e = (b.w == '0) || (b.h == '0);
    touch_x = ({1'b0, a.x} <= rb) && ({1'b0, b.x} <= ra);
    touch_y = ({1'b0, a.y} <= bb) && ({1'b0, b.y} <= ba);
    res.merge_ok = !a_e && !b_e && (!res.clip_empty ||
                   (a.y == b.y && a.h == b.h && touch_x) ||
                   (a.x == b.x && a.w == b.w && touch_y));
  end
endmodule

FILE: hw/rtl/drrm_stats.sv
// ----------------------------------------------------------------------------
// drrm_stats
// Saturating statistics counters, area product registered before the adds.
// ----------------------------------------------------------------------------
module drrm_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        area_load,
  input  logic [15:0] area_w,
  input  logic [15:0] area_h,
  input  logic        area_add,
  input  logic        merge_inc,
  input  logic        fallback_inc,
  output logic [31:0] appends_seen,
  output logic [31:0] merges_done,
  output logic [31:0] fallbacks_done,
  output logic [47:0] pixels_presented,
  output logic [31:0] largest_area
);
  logic [31:0] area;
  logic [48:0] psum;

  assign psum = {1'b0, pixels_presented} + {17'd0, area};

  always_ff @(posedge clk) begin
    if (area_load) area <= area_w * area_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      appends_seen <= '0;
      merges_done <= '0;
      fallbacks_done <= '0;
      pixels_presented <= '0;
      largest_area <= '0;
    end else begin
      if (area_add) begin
        if (appends_seen != '1) appends_seen <= appends_seen + 32'd1;
        pixels_presented <= psum[48] ? '1 : psum[47:0];
        if (area > largest_area) largest_area <= area;
      end
      if (merge_inc && merges_done != '1) merges_done <= merges_done + 32'd1;
      if (fallback_inc && fallbacks_done != '1) fallbacks_done <= fallbacks_done + 32'd1;
    end
  end
endmodule

FILE: hw/rtl/dirty_rect_region_merger.sv
// ----------------------------------------------------------------------------
// dirty_rect_region_merger
// Damage-region list with clip, merge cascade and full-screen fallback.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_axis  | in        | tuser=func, tdata=rect_x,rect_y,rect_width,rect_height,region_index
// m_axis  | out       | tdata=status,out_*,live_regions,in_fallback,statistics
// cfg     | in        | cfg_index (0..3 bounds), cfg_data
//
// Clear, read, function code three and appends clipped to nothing go straight
// to the result; an append during fallback also waits for the area product
// and the statistics update. A queued append scans the stored regions one by
// one; a merge then compares stored regions in each pass of the cascade.
// Reset is synchronous; the list is held in flip-flops and is empty after reset.
// The input stalls while an item is in work or a result waits to be taken.
module dirty_rect_region_merger #(
  parameter int MAX_REGIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: rect_x, rect_y, rect_width, rect_height, region_index (lowest first)
  input  logic [71:0]  s_axis_tdata,
  // tuser: func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, out_x, out_y, out_width, out_height, live_regions,
  // in_fallback, appends_seen, merges_done, fallbacks_done, pixels_presented,
  // largest_area (lowest first)
  output logic [255:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import drrm_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLIP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CASC  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state;
  box_t          store [MAX_REGIONS];
  logic [CW-1:0] count;
  logic          fb;
  box_t          bnd, rin, cur;
  logic [1:0]    func;
  logic [3:0]    ridx;
  logic [CW-1:0] i, k;
  logic [IW-1:0] gi;
  logic [2:0]    status;
  box_t          rd;
  geo_t          g;
  box_t          ga, gb;
  logic          area_load, area_add, merge_inc, fallback_inc;
  logic [31:0]   appends_seen, merges_done, fallbacks_done, largest_area;
  logic [47:0]   pixels_presented;
  logic [CW-1:0] last;
  logic          area_pend;
  logic          bnd_live;

  assign last = count - CW'(1);
  assign bnd_live = (bnd.w != '0) && (bnd.h != '0);
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  // The result is offered once every statistics update has landed.
  assign m_axis_tvalid = (state == S_OUT) && !area_pend && !area_add &&
                         !merge_inc && !fallback_inc;

  // Geometry operands per state: clip input to bounds, compare a stored box with the input, or compare stored boxes.
  always_comb begin
    ga = bnd;
    gb = rin;
    gi = IW'(k);
    if (state == S_SCAN) begin
      ga = store[IW'(i)];
      gb = rin;
    end else if (state == S_CASC) begin
      ga = store[IW'(i)];
      gb = store[gi];
    end
  end

  drrm_geom u_geom (.a(ga), .b(gb), .res(g));

  drrm_stats u_stats (
    .clk(clk), .rst(rst), .area_load(area_load), .area_w(rin.w), .area_h(rin.h),
    .area_add(area_add), .merge_inc(merge_inc), .fallback_inc(fallback_inc),
    .appends_seen(appends_seen), .merges_done(merges_done),
    .fallbacks_done(fallbacks_done), .pixels_presented(pixels_presented),
    .largest_area(largest_area)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOUND_X: bnd.x <= cfg_data;
        REG_BOUND_Y: bnd.y <= cfg_data;
        REG_BOUND_W: bnd.w <= cfg_data;
        REG_BOUND_H: bnd.h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area_load <= 1'b0;
    area_add <= 1'b0;
    merge_inc <= 1'b0;
    fallback_inc <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      fb <= 1'b0;
      area_pend <= 1'b0;
      for (int n = 0; n < MAX_REGIONS; n++) store[n] <= '0;
    end else begin
      if (area_pend) begin
        area_add <= 1'b1;
        area_pend <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func <= s_axis_tuser;
            rin <= s_axis_tdata[63:0];
            ridx <= s_axis_tdata[67:64];
            rd <= '0;
            status <= ST_IGNORED;
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          if (func == FN_CLEAR) begin
            for (int n = 0; n < MAX_REGIONS; n++) store[n] <= '0;
            count <= '0;
            fb <= 1'b0;
            status <= ST_DONE;
            state <= S_OUT;
          end else if (func == FN_READ) begin
            if ({1'b0, ridx} < 5'(count) && 32'(ridx) < MAX_REGIONS)
              rd <= store[IW'(ridx)];
            status <= ST_DONE;
            state <= S_OUT;
          end else if (func == FN_APPEND && !g.clip_empty) begin
            rin <= g.clip;
            // Area is taken from the clipped box next cycle.
            area_pend <= 1'b1;
            area_load <= 1'b1;
            i <= '0;
            if (fb) status <= ST_FALLBACK;
            state <= fb ? S_OUT : S_SCAN;
          end else begin
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          if (32'(i) >= 32'(count)) begin
            if (32'(count) >= MAX_REGIONS) begin
              for (int n = 0; n < MAX_REGIONS; n++)
                store[n] <= (n == 0 && bnd_live) ? bnd : '0;
              fb <= 1'b1;
              fallback_inc <= 1'b1;
              count <= bnd_live ? CW'(1) : '0;
              status <= ST_FALLBACK;
            end else begin
              store[IW'(count)] <= rin;
              count <= count + CW'(1);
              status <= ST_QUEUED;
            end
            state <= S_OUT;
          end else if (g.merge_ok) begin
            store[IW'(i)] <= g.hull;
            k <= '0;
            state <= S_CASC;
          end else begin
            i <= i + CW'(1);
          end
        end
        S_CASC: begin
          if (32'(k) >= 32'(count)) begin
            merge_inc <= 1'b1;
            status <= ST_MERGED;
            state <= S_OUT;
          end else if (k != i && g.merge_ok) begin
            count <= last;
            merge_inc <= 1'b1;
            if (i == last) begin
              // The grown box leaves the last slot for the freed hole, and the
              // cascade ends on the next cycle.
              store[IW'(k)] <= g.hull;
              store[IW'(i)] <= '0;
              k <= last;
            end else begin
              store[IW'(i)] <= g.hull;
              if (k != last) store[IW'(k)] <= store[IW'(last)];
              store[IW'(last)] <= '0;
              k <= '0;
            end
          end else begin
            k <= k + CW'(1);
          end
        end
        S_OUT: begin
          if (m_axis_tready && m_axis_tvalid) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {
    7'd0, largest_area, pixels_presented, fallbacks_done, merges_done, appends_seen,
    fb, 5'(count), rd.h, rd.w, rd.y, rd.x, status
  };

  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_REGIONS)
    else $error("region count above capacity");
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !m_axis_tvalid)
    else $error("accepting while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_CASC) |-> !fb)
    else $error("list scanned during fallback");
endmodule
